// File: design/eased_tween_table_engine_top_macros.svh
// Assertion macros used by the tween engine controller.
// No dependencies; simulation builds get the checks and synthesis gets empty bodies.
`ifndef EASED_TWEEN_TABLE_ENGINE_TOP_MACROS_SVH
`define EASED_TWEEN_TABLE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define ETT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tween engine assertion failed");
// Condition that must never be true.
`define ETT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ETT_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define ETT_ASSERT(lbl, clk, rst_n, prop)
`define ETT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/ett_pkg.sv
// Shared types and constants of the tween table engine.
// No dependencies.
`timescale 1ns / 1ps
package ett_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int ELASTIC_DEPTH_DEF = 256;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam int DIV_STEPS = 16;
    localparam int EASE_W = 18;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint LN2_Q30    = 64'sd744261118;
    localparam longint HALFPI_Q30 = 64'sd1686629713;

    typedef enum logic [2:0] {
        KIND_STARTED  = 3'd0,
        KIND_REFUSED  = 3'd1,
        KIND_RUNNING  = 3'd2,
        KIND_FINISHED = 3'd3,
        KIND_ACK      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]         target;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [31:0]        start_frame;
        logic [15:0]        duration;
        logic [2:0]         easing;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic  capture;
        logic  ram_re;
        logic  ram_we;
        logic  wr_from_input;
        logic  eval;
        logic  div_step;
        logic  ease0;
        logic  ease1;
        logic  ease2;
        logic  mul;
        logic  sum;
        logic  out_load;
        kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic finish;
        logic div_done;
    } status_t;

endpackage

// File: design/ett_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ett_datapath.sv
// Datapath of the tween engine: entry table, divider, easing curves, interpolation.
// Depends on ett_pkg and ett_ram.
`timescale 1ns / 1ps
module ett_datapath #(
    parameter int MAX_SLOTS = ett_pkg::MAX_SLOTS_DEF,
    parameter int ELASTIC_DEPTH = ett_pkg::ELASTIC_DEPTH_DEF,
    parameter int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          target_id,
    input  logic signed [31:0]  start_value,
    input  logic signed [31:0]  end_value,
    input  logic [15:0]         duration,
    input  logic [2:0]          easing,
    input  logic [31:0]         frame_number,
    input  ett_pkg::cmd_t       cmd,
    input  logic [IDX_W-1:0]    raddr,
    input  logic [IDX_W-1:0]    waddr,
    output ett_pkg::status_t    status,
    output logic [7:0]          target_id_res,
    output logic signed [31:0]  value
);

    localparam int ROM_W = (ELASTIC_DEPTH > 1) ? $clog2(ELASTIC_DEPTH) : 1;
    localparam int TD_W = 16 + ROM_W;

    typedef enum logic [3:0] {
        EM_LIN, EM_SQ16, EM_INV16, EM_SQ15, EM_INV17,
        EM_B0, EM_B1, EM_B2, EM_B3, EM_ROM
    } ease_mode_t;

    // Elastic curve table, built at elaboration.
    logic [ett_pkg::EASE_W-1:0] rom_table [ELASTIC_DEPTH];

    for (genvar k = 0; k < ELASTIC_DEPTH; k++)
    begin : g_rom
        localparam longint KK = k;
        localparam longint D = ELASTIC_DEPTH;
        localparam longint Y = 10 * KK;
        localparam longint N = Y / ELASTIC_DEPTH;
        localparam longint FR = ((Y % ELASTIC_DEPTH) <<< 30) / ELASTIC_DEPTH;
        localparam longint Z = (FR * ett_pkg::LN2_Q30) >>> 30;
        localparam longint T9 = ett_pkg::Q30_ONE - ((Z * ett_pkg::Q30_ONE) >>> 30) / 9;
        localparam longint T8 = ett_pkg::Q30_ONE - ((Z * T9) >>> 30) / 8;
        localparam longint T7 = ett_pkg::Q30_ONE - ((Z * T8) >>> 30) / 7;
        localparam longint T6 = ett_pkg::Q30_ONE - ((Z * T7) >>> 30) / 6;
        localparam longint T5 = ett_pkg::Q30_ONE - ((Z * T6) >>> 30) / 5;
        localparam longint T4 = ett_pkg::Q30_ONE - ((Z * T5) >>> 30) / 4;
        localparam longint T3 = ett_pkg::Q30_ONE - ((Z * T4) >>> 30) / 3;
        localparam longint T2 = ett_pkg::Q30_ONE - ((Z * T3) >>> 30) / 2;
        localparam longint T1 = ett_pkg::Q30_ONE - ((Z * T2) >>> 30) / 1;
        localparam longint AMP = (N < 62) ? (T1 >>> N) : 64'sd0;
        localparam longint QUARTER = 3 * D;
        localparam longint FULL = 12 * D;
        localparam longint Q0 = (40 * KK - QUARTER) % FULL;
        localparam longint Q = (Q0 < 0) ? Q0 + FULL : Q0;
        localparam longint QUAD = Q / QUARTER;
        localparam longint W = Q % QUARTER;
        localparam longint X = ((QUAD % 2) == 1) ? QUARTER - W : W;
        localparam longint A = (X * ett_pkg::HALFPI_Q30) / QUARTER;
        localparam longint A2 = (A * A) >>> 30;
        localparam longint S1 = ett_pkg::Q30_ONE - ((A2 * ett_pkg::Q30_ONE) >>> 30) / 110;
        localparam longint S2 = ett_pkg::Q30_ONE - ((A2 * S1) >>> 30) / 72;
        localparam longint S3 = ett_pkg::Q30_ONE - ((A2 * S2) >>> 30) / 42;
        localparam longint S4 = ett_pkg::Q30_ONE - ((A2 * S3) >>> 30) / 20;
        localparam longint S5 = ett_pkg::Q30_ONE - ((A2 * S4) >>> 30) / 6;
        localparam longint SN = (A * S5) >>> 30;
        localparam longint S = (QUAD >= 2) ? -SN : SN;
        localparam longint PROD = AMP * S;
        localparam longint MAG = (PROD < 0) ? -PROD : PROD;
        localparam longint MAG2 = (MAG + (64'sd1 <<< 43)) >>> 44;
        localparam longint ENTRY = (KK == 0) ? 64'sd0
                                 : 64'sd65536 + ((PROD < 0) ? -MAG2 : MAG2);
        assign rom_table[k] = ett_pkg::EASE_W'(ENTRY);
    end

    // Captured input item.
    logic [7:0]         in_target_reg;
    logic signed [31:0] in_start_reg;
    logic signed [31:0] in_end_reg;
    logic [15:0]        in_dur_reg;
    logic [2:0]         in_easing_reg;
    logic [31:0]        frame_reg;

    ett_pkg::entry_t rd_entry;
    ett_pkg::entry_t wr_entry;
    logic [ett_pkg::ENTRY_W-1:0] rd_bits;

    always_comb
    begin
        wr_entry.target      = in_target_reg;
        wr_entry.start_value = in_start_reg;
        wr_entry.end_value   = in_end_reg;
        wr_entry.start_frame = frame_reg;
        wr_entry.duration    = in_dur_reg;
        wr_entry.easing      = in_easing_reg;
    end

    ett_ram #(
        .WIDTH(ett_pkg::ENTRY_W),
        .DEPTH(MAX_SLOTS),
        .AW(IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (waddr),
        .wdata (cmd.wr_from_input ? wr_entry : rd_entry),
        .re    (cmd.ram_re),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    assign rd_entry = ett_pkg::entry_t'(rd_bits);

    logic        finish_reg;
    logic [16:0] rem_reg;
    logic [15:0] quo_reg;
    logic [4:0]  div_cnt_reg;
    logic [31:0] elapsed;
    logic [16:0] rem_sh;

    ease_mode_t  mode_reg;
    logic [19:0] op_reg;
    logic [39:0] sq_reg;
    logic [ROM_W-1:0] rom_idx_reg;
    logic [ett_pkg::EASE_W-1:0] rom_reg;
    logic [ett_pkg::EASE_W-1:0] e_reg;
    logic signed [51:0] prod_reg;
    logic signed [31:0] val_reg;
    logic [7:0]         target_out_reg;
    logic signed [31:0] value_out_reg;

    ease_mode_t  mode_next;
    logic [19:0] op_next;
    logic [TD_W-1:0] t_times_d;
    logic [19:0] t11;
    logic signed [22:0] b_diff;
    logic [ett_pkg::EASE_W-1:0] e_next;
    logic signed [32:0] diff;
    logic signed [36:0] sum;
    logic signed [31:0] sat;

    assign elapsed = frame_reg - rd_entry.start_frame;
    assign rem_sh = {rem_reg[15:0], 1'b0};
    assign t_times_d = TD_W'(quo_reg) * TD_W'(ELASTIC_DEPTH);
    assign t11 = 20'(quo_reg) * 20'd11;

    // Square operand and curve segment for the current phase.
    always_comb
    begin
        mode_next = EM_LIN;
        op_next = 20'd0;
        b_diff = 23'sd0;
        case (rd_entry.easing)
            3'd1:
            begin
                mode_next = EM_SQ16;
                op_next = 20'(quo_reg);
            end
            3'd2:
            begin
                mode_next = EM_INV16;
                op_next = 20'd65536 - 20'(quo_reg);
            end
            3'd3:
            begin
                if (!quo_reg[15])
                begin
                    mode_next = EM_SQ15;
                    op_next = 20'(quo_reg);
                end
                else
                begin
                    mode_next = EM_INV17;
                    op_next = 20'd131072 - {3'd0, quo_reg, 1'b0};
                end
            end
            3'd4:
            begin
                if (t11 < 20'd262144)
                begin
                    mode_next = EM_B0;
                    b_diff = 23'(t11);
                end
                else if (t11 < 20'd524288)
                begin
                    mode_next = EM_B1;
                    b_diff = 23'(t11) - 23'sd393216;
                end
                else if (t11 < 20'd655360)
                begin
                    mode_next = EM_B2;
                    b_diff = 23'(t11) - 23'sd589824;
                end
                else
                begin
                    mode_next = EM_B3;
                    b_diff = {2'd0, t11, 1'b0} - 23'sd1376256;
                end
                op_next = (b_diff < 0) ? 20'(-b_diff) : 20'(b_diff);
            end
            3'd5:
            begin
                mode_next = EM_ROM;
            end
            default:
            begin
                mode_next = EM_LIN;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            EM_SQ16:  e_next = ett_pkg::EASE_W'(sq_reg >> 16);
            EM_INV16: e_next = 18'd65536 - ett_pkg::EASE_W'(sq_reg >> 16);
            EM_SQ15:  e_next = ett_pkg::EASE_W'(sq_reg >> 15);
            EM_INV17: e_next = 18'd65536 - ett_pkg::EASE_W'(sq_reg >> 17);
            EM_B0:    e_next = ett_pkg::EASE_W'(sq_reg >> 20);
            EM_B1:    e_next = ett_pkg::EASE_W'(sq_reg >> 20) + 18'd49152;
            EM_B2:    e_next = ett_pkg::EASE_W'(sq_reg >> 20) + 18'd61440;
            EM_B3:    e_next = ett_pkg::EASE_W'(sq_reg >> 22) + 18'd64512;
            EM_ROM:   e_next = rom_reg;
            default:  e_next = ett_pkg::EASE_W'(quo_reg);
        endcase
    end

    assign diff = 33'(rd_entry.end_value) - 33'(rd_entry.start_value);
    assign sum = 37'(rd_entry.start_value) + 37'(prod_reg >>> 16);

    always_comb
    begin
        if (sum > 37'sd2147483647)
        begin
            sat = 32'sh7fffffff;
        end
        else if (sum < -37'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = 32'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= 5'd0;
        end
        else if (cmd.eval)
        begin
            div_cnt_reg <= 5'd0;
        end
        else if (cmd.div_step && (div_cnt_reg != 5'(ett_pkg::DIV_STEPS)))
        begin
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_target_reg <= target_id;
            in_start_reg  <= start_value;
            in_end_reg    <= end_value;
            in_dur_reg    <= duration;
            in_easing_reg <= easing;
            frame_reg     <= frame_number;
        end
        if (cmd.eval)
        begin
            finish_reg <= (elapsed >= {16'd0, rd_entry.duration});
            rem_reg <= {1'b0, elapsed[15:0]};
            quo_reg <= 16'd0;
        end
        else if (cmd.div_step && (div_cnt_reg != 5'(ett_pkg::DIV_STEPS)))
        begin
            if (rem_sh >= {1'b0, rd_entry.duration})
            begin
                rem_reg <= rem_sh - {1'b0, rd_entry.duration};
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.ease0)
        begin
            mode_reg <= mode_next;
            op_reg <= op_next;
            rom_idx_reg <= t_times_d[16 +: ROM_W];
        end
        if (cmd.ease1)
        begin
            sq_reg <= 40'(op_reg) * 40'(op_reg);
            rom_reg <= rom_table[rom_idx_reg];
        end
        if (cmd.ease2)
        begin
            e_reg <= e_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= 52'(diff * $signed({1'b0, e_reg}));
        end
        if (cmd.sum)
        begin
            val_reg <= sat;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                ett_pkg::KIND_STARTED:
                begin
                    target_out_reg <= in_target_reg;
                    value_out_reg <= in_start_reg;
                end
                ett_pkg::KIND_REFUSED:
                begin
                    target_out_reg <= in_target_reg;
                    value_out_reg <= 32'sd0;
                end
                ett_pkg::KIND_RUNNING:
                begin
                    target_out_reg <= rd_entry.target;
                    value_out_reg <= val_reg;
                end
                ett_pkg::KIND_FINISHED:
                begin
                    target_out_reg <= rd_entry.target;
                    value_out_reg <= rd_entry.end_value;
                end
                default:
                begin
                    target_out_reg <= 8'd0;
                    value_out_reg <= 32'sd0;
                end
            endcase
        end
    end

    assign status.finish = finish_reg;
    assign status.div_done = (div_cnt_reg == 5'(ett_pkg::DIV_STEPS));
    assign target_id_res = target_out_reg;
    assign value = value_out_reg;

endmodule

// File: design/ett_ctrl.sv
// Controller of the tween engine: item handshakes, table walk and compaction.
// Depends on ett_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "eased_tween_table_engine_top_macros.svh"
module ett_ctrl #(
    parameter int MAX_SLOTS = ett_pkg::MAX_SLOTS_DEF,
    parameter int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int CNT_W = $clog2(MAX_SLOTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       action,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [2:0]       result_kind,
    output logic [4:0]       slot,
    output logic             last,
    output ett_pkg::cmd_t    cmd,
    input  ett_pkg::status_t status,
    output logic [IDX_W-1:0] raddr,
    output logic [IDX_W-1:0] waddr
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START_WR, ST_EMIT, ST_RD, ST_EVAL, ST_CHK, ST_DIV,
        ST_EASE0, ST_EASE1, ST_EASE2, ST_MUL, ST_SUM, ST_RES
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] pend_slot_reg, pend_slot_next;
    ett_pkg::kind_t pend_kind_reg, pend_kind_next;
    logic rsp_valid_reg, rsp_valid_next;
    ett_pkg::kind_t kind_reg, kind_next;
    logic [4:0] slot_reg, slot_next;
    logic last_reg, last_next;
    logic out_free;
    logic walk_last;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign walk_last = (r_reg == count_reg - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        r_next = r_reg;
        w_next = w_reg;
        pend_slot_next = pend_slot_reg;
        pend_kind_next = pend_kind_reg;
        kind_next = kind_reg;
        slot_next = slot_reg;
        last_next = last_reg;
        rsp_valid_next = rsp_stall ? rsp_valid_reg : 1'b0;
        cmd = '0;
        cmd.out_kind = pend_kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    pend_slot_next = '0;
                    pend_kind_next = ett_pkg::KIND_ACK;
                    state_next = ST_EMIT;
                    case (action)
                        ett_pkg::ACT_START:
                        begin
                            if (count_reg >= CNT_W'(MAX_SLOTS))
                            begin
                                pend_kind_next = ett_pkg::KIND_REFUSED;
                            end
                            else
                            begin
                                pend_kind_next = ett_pkg::KIND_STARTED;
                                state_next = ST_START_WR;
                            end
                        end
                        ett_pkg::ACT_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                r_next = '0;
                                w_next = '0;
                                state_next = ST_RD;
                            end
                        end
                        ett_pkg::ACT_STOP:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            pend_kind_next = ett_pkg::KIND_ACK;
                        end
                    endcase
                end
            end
            ST_START_WR:
            begin
                cmd.ram_we = 1'b1;
                cmd.wr_from_input = 1'b1;
                pend_slot_next = count_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    rsp_valid_next = 1'b1;
                    kind_next = pend_kind_reg;
                    slot_next = 5'(pend_slot_reg);
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.ram_re = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (status.finish)
                begin
                    pend_kind_next = ett_pkg::KIND_FINISHED;
                    state_next = ST_RES;
                end
                else
                begin
                    pend_kind_next = ett_pkg::KIND_RUNNING;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EASE0;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EASE0:
            begin
                cmd.ease0 = 1'b1;
                state_next = ST_EASE1;
            end
            ST_EASE1:
            begin
                cmd.ease1 = 1'b1;
                state_next = ST_EASE2;
            end
            ST_EASE2:
            begin
                cmd.ease2 = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    rsp_valid_next = 1'b1;
                    kind_next = pend_kind_reg;
                    slot_next = 5'(r_reg);
                    last_next = walk_last;
                    if (pend_kind_reg == ett_pkg::KIND_RUNNING)
                    begin
                        // Survivors move down over retired entries, keeping order.
                        cmd.ram_we = 1'b1;
                        w_next = w_reg + CNT_W'(1);
                    end
                    r_next = r_reg + CNT_W'(1);
                    if (walk_last)
                    begin
                        count_next = w_next;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            r_reg <= '0;
            w_reg <= '0;
            pend_slot_reg <= '0;
            pend_kind_reg <= ett_pkg::KIND_ACK;
            rsp_valid_reg <= 1'b0;
            kind_reg <= ett_pkg::KIND_ACK;
            slot_reg <= 5'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            r_reg <= r_next;
            w_reg <= w_next;
            pend_slot_reg <= pend_slot_next;
            pend_kind_reg <= pend_kind_next;
            rsp_valid_reg <= rsp_valid_next;
            kind_reg <= kind_next;
            slot_reg <= slot_next;
            last_reg <= last_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign result_kind = kind_reg;
    assign slot = slot_reg;
    assign last = last_reg;
    assign raddr = r_reg[IDX_W-1:0];
    assign waddr = (state_reg == ST_START_WR) ? count_reg[IDX_W-1:0] : w_reg[IDX_W-1:0];

    `ETT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_SLOTS))
    `ETT_ASSERT(a_compact_order, clk, rst_n, w_reg <= r_reg || state_reg == ST_IDLE || state_reg == ST_EMIT || state_reg == ST_START_WR)
    `ETT_ASSERT_NEVER(a_load_over_held, clk, rst_n, cmd.out_load && rsp_valid_reg && rsp_stall)
    `ETT_ASSERT(a_walk_nonempty, clk, rst_n, (state_reg != ST_RD) || (r_reg < count_reg))

endmodule

// File: design/eased_tween_table_engine_top.sv
// Tween engine: a start or stop needs no table walk; a tick walks every entry, and each
// running entry also takes its phase from a 16-step divider.
// One item is worked on at a time; a new item is taken as soon as the controller is idle,
// even while the last result still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the table; entry storage is not
// cleared, as only entries below the fill count are ever read.
`timescale 1ns / 1ps
module eased_tween_table_engine_top #(
    parameter int MAX_SLOTS = ett_pkg::MAX_SLOTS_DEF,
    parameter int ELASTIC_DEPTH = ett_pkg::ELASTIC_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         action,
    input  logic [7:0]         target_id,
    input  logic signed [31:0] start_value,
    input  logic signed [31:0] end_value,
    input  logic [15:0]        duration,
    input  logic [2:0]         easing,
    input  logic [31:0]        frame_number,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         result_kind,
    output logic [4:0]         slot,
    output logic [7:0]         target_id_res,
    output logic signed [31:0] value,
    output logic               last
);

    // Index width of the entry table; the fill count needs one more value.
    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    ett_pkg::cmd_t    cmd;
    ett_pkg::status_t status;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;

    // The controller sequences each item and owns the result handshake and the
    // kind, slot and last fields of each result.
    ett_ctrl #(
        .MAX_SLOTS(MAX_SLOTS),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .action      (action),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_kind (result_kind),
        .slot        (slot),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .raddr       (raddr),
        .waddr       (waddr)
    );

    // The datapath holds the table and computes the value of each result.
    ett_datapath #(
        .MAX_SLOTS(MAX_SLOTS),
        .ELASTIC_DEPTH(ELASTIC_DEPTH),
        .IDX_W(IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_id     (target_id),
        .start_value   (start_value),
        .end_value     (end_value),
        .duration      (duration),
        .easing        (easing),
        .frame_number  (frame_number),
        .cmd           (cmd),
        .raddr         (raddr),
        .waddr         (waddr),
        .status        (status),
        .target_id_res (target_id_res),
        .value         (value)
    );

endmodule

// File: test/tb_eased_tween_table_engine_top.sv
// Self-checking testbench for eased_tween_table_engine_top.
// A directed table of items is followed by random start, tick, stop and unused-code sequences.
// Every result is checked against a built-in predictor of the tween table.
// Depends on ett_pkg and the engine RTL only.
`timescale 1ns / 1ps
module tb_eased_tween_table_engine_top;
    import ett_pkg::*;

    localparam int TABLE_SLOTS = MAX_SLOTS_DEF;
    localparam int IDLE_LIMIT = 12000;
    localparam int RANDOM_ITEMS = 210;
    localparam int LONG_HOLD = 3000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // One request item, plus the result typed in for the directed rows.
    typedef struct {
        logic [1:0]         act;
        logic [7:0]         tgt;
        logic signed [31:0] from_val;
        logic signed [31:0] to_val;
        logic [15:0]        frames;
        logic [2:0]         curve;
        logic [31:0]        frame;
        bit                 has_typed;
        kind_t              typed_kind;
        logic [31:0]        typed_value;
    } tween_req_t;

    // One result item as the engine should deliver it.
    typedef struct {
        kind_t       kind;
        logic [4:0]  slot;
        logic [7:0]  tgt;
        logic [31:0] val;
        logic        last;
    } tween_res_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         action;
    logic [7:0]         target_id;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic [15:0]        duration;
    logic [2:0]         easing;
    logic [31:0]        frame_number;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [2:0]         result_kind;
    logic [4:0]         slot;
    logic [7:0]         target_id_res;
    logic signed [31:0] value;
    logic               last;

    // Typed-in expectation travels with the payload of the directed rows.
    logic               typed_valid;
    kind_t              typed_kind;
    logic [31:0]        typed_value;

    // Predictor state: the tween table as the engine should hold it.
    entry_t      tween_table [TABLE_SLOTS];
    int          tween_count;
    tween_res_t  pending_results[$];

    int  err_count;
    int  idle_cycles;
    bit  hold_req;
    int  burst_left;
    logic [31:0] cur_frame;

    eased_tween_table_engine_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .target_id    (target_id),
        .start_value  (start_value),
        .end_value    (end_value),
        .duration     (duration),
        .easing       (easing),
        .frame_number (frame_number),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_kind  (result_kind),
        .slot         (slot),
        .target_id_res(target_id_res),
        .value        (value),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
        err_count++;
    endtask

    // e^-z in Q30 by a Horner-evaluated Taylor series, with floors.
    function automatic longint exp_decay_q30(longint z);
        longint term;
        term = Q30_ONE;
        for (int j = 9; j >= 1; j--)
            term = Q30_ONE - ((z * term) >>> 30) / j;
        return term;
    endfunction

    // Sine on the quarter wave in Q30.
    function automatic longint sine_q30(longint a);
        longint dv [5];
        longint a2;
        longint term;
        dv = '{110, 72, 42, 20, 6};
        a2 = (a * a) >>> 30;
        term = Q30_ONE;
        for (int j = 0; j < 5; j++)
            term = Q30_ONE - ((a2 * term) >>> 30) / dv[j];
        return (a * term) >>> 30;
    endfunction

    // Elastic curve, sampled at the ROM index the phase falls on.
    function automatic longint elastic_curve(longint t);
        longint d, k, y, n, frac, amp, quarter, full, q, quad, w, x, s, prod, mag;
        d = ELASTIC_DEPTH_DEF;
        k = (t * d) >>> 16;
        if (k <= 0)
            return 0;
        y = 10 * k;
        n = y / d;
        frac = ((y % d) <<< 30) / d;
        amp = exp_decay_q30((frac * LN2_Q30) >>> 30);
        amp = (n < 62) ? (amp >>> n) : 0;
        quarter = 3 * d;
        full = 12 * d;
        q = (40 * k - quarter) % full;
        if (q < 0)
            q += full;
        quad = q / quarter;
        w = q % quarter;
        x = quad[0] ? quarter - w : w;
        s = sine_q30((x * HALFPI_Q30) / quarter);
        if (quad >= 2)
            s = -s;
        prod = amp * s;
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + (64'sd1 <<< 43)) >>> 44;
        return 65536 + ((prod < 0) ? -mag : mag);
    endfunction

    // Eased phase in Q16.16 for a Q0.16 phase t.
    function automatic longint eased_phase(longint t, logic [2:0] curve);
        longint t11;
        t11 = 11 * t;
        case (curve)
            3'd1: return (t * t) >>> 16;
            3'd2: return 65536 - (((65536 - t) * (65536 - t)) >>> 16);
            3'd3:
            begin
                if (t < 32768)
                    return (2 * t * t) >>> 16;
                return 65536 - (((131072 - 2 * t) * (131072 - 2 * t)) >>> 17);
            end
            3'd4:
            begin
                if (t11 < 4 * 65536)
                    return (t11 * t11) >>> 20;
                if (t11 < 8 * 65536)
                    return (((t11 - 6 * 65536) * (t11 - 6 * 65536)) >>> 20) + 49152;
                if (t11 < 10 * 65536)
                    return (((t11 - 9 * 65536) * (t11 - 9 * 65536)) >>> 20) + 61440;
                return (((22 * t - 21 * 65536) * (22 * t - 21 * 65536)) >>> 22) + 64512;
            end
            3'd5: return elastic_curve(t);
            default: return t;
        endcase
    endfunction

    function automatic logic [31:0] saturate32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Applies one accepted item to the predicted table and queues its results.
    task automatic predict_tween_results(logic [1:0] act, logic [7:0] tgt,
                                         logic signed [31:0] from_val,
                                         logic signed [31:0] to_val, logic [15:0] frames,
                                         logic [2:0] curve, logic [31:0] frame);
        tween_res_t r;
        entry_t     kept [TABLE_SLOTS];
        int         n_kept;
        logic [31:0] elapsed;
        logic [47:0] phase;
        longint     diff;
        longint     eased;
        int         first_idx;
        first_idx = pending_results.size();
        n_kept = 0;
        if (act == ACT_START)
        begin
            if (tween_count >= TABLE_SLOTS)
                r = '{KIND_REFUSED, 5'd0, tgt, 32'd0, 1'b1};
            else
            begin
                tween_table[tween_count] = '{tgt, from_val, to_val, frame, frames, curve};
                r = '{KIND_STARTED, tween_count[4:0], tgt, from_val, 1'b1};
                tween_count++;
            end
            pending_results.push_back(r);
        end
        else if (act == ACT_TICK && tween_count > 0)
        begin
            for (int i = 0; i < tween_count; i++)
            begin
                elapsed = frame - tween_table[i].start_frame;
                if (elapsed >= tween_table[i].duration)
                    r = '{KIND_FINISHED, i[4:0], tween_table[i].target,
                          tween_table[i].end_value, 1'b0};
                else
                begin
                    phase = {elapsed, 16'd0} / tween_table[i].duration;
                    eased = eased_phase(longint'(phase), tween_table[i].easing);
                    diff = longint'(tween_table[i].end_value)
                           - longint'(tween_table[i].start_value);
                    r = '{KIND_RUNNING, i[4:0], tween_table[i].target,
                          saturate32(longint'(tween_table[i].start_value)
                                     + ((diff * eased) >>> 16)), 1'b0};
                    kept[n_kept] = tween_table[i];
                    n_kept++;
                end
                r.last = (i == tween_count - 1);
                pending_results.push_back(r);
            end
            // Finished entries drop out and the survivors close up in order.
            for (int i = 0; i < n_kept; i++)
                tween_table[i] = kept[i];
            tween_count = n_kept;
        end
        else
        begin
            if (act == ACT_STOP)
                tween_count = 0;
            pending_results.push_back('{KIND_ACK, 5'd0, 8'd0, 32'd0, 1'b1});
        end
        // Some directed rows carry a hand-written first result to cross-check the predictor.
        if (typed_valid)
        begin
            if (pending_results[first_idx].kind != typed_kind)
                report_mismatch("typed kind", pending_results[first_idx].kind, typed_kind);
            if (pending_results[first_idx].val != typed_value)
                report_mismatch("typed value", pending_results[first_idx].val, typed_value);
        end
    endtask

    // Acceptance on both channels is sampled at the rising edge, before any
    // stimulus update of the same step takes effect.
    always @(posedge clk)
    begin
        tween_res_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("MISMATCH at %0t: result item with nothing expected", $realtime);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind != want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (slot != want.slot)
                    report_mismatch("slot", slot, want.slot);
                if (target_id_res != want.tgt)
                    report_mismatch("target_id_res", target_id_res, want.tgt);
                if (value !== want.val)
                    report_mismatch("value", value, want.val);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
        if (rst_n && req_valid && !req_stall)
            predict_tween_results(action, target_id, start_value, end_value, duration,
                                  easing, frame_number);
    end

    // Watchdog: a run that moves no item on either side for too long has hung.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("eased_tween_table_engine_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // The receiver stalls on a pattern of its own whose density changes at random,
    // including stretches with no stall at all. On request it holds off for a long
    // stretch so that the engine backs up into its input.
    initial
    begin
        int stall_pct;
        int mode_left;
        rsp_stall = 1'b0;
        stall_pct = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offers one item and holds it until it is accepted. Items leave in bursts;
    // between bursts the valid mostly drops for a random gap.
    task automatic send_item(tween_req_t it);
        req_valid    <= 1'b1;
        action       <= it.act;
        target_id    <= it.tgt;
        start_value  <= it.from_val;
        end_value    <= it.to_val;
        duration     <= it.frames;
        easing       <= it.curve;
        frame_number <= it.frame;
        typed_valid  <= it.has_typed;
        typed_kind   <= it.typed_kind;
        typed_value  <= it.typed_value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 10);
            if ($urandom_range(0, 2) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Builds a request item; the typed-in expectation stays off.
    function automatic tween_req_t mk_req(logic [1:0] act, logic [7:0] tgt,
                                          logic [31:0] from_val, logic [31:0] to_val,
                                          logic [15:0] frames, logic [2:0] curve,
                                          logic [31:0] frame);
        tween_req_t it;
        it = '{act, tgt, from_val, to_val, frames, curve, frame, 1'b0, KIND_ACK, 32'd0};
        return it;
    endfunction

    function automatic tween_req_t mk_typed(tween_req_t it, kind_t k, logic [31:0] v);
        it.has_typed = 1'b1;
        it.typed_kind = k;
        it.typed_value = v;
        return it;
    endfunction

    // Random tween start at the running frame, mostly short tweens.
    function automatic tween_req_t random_start();
        logic [15:0] frames;
        case ($urandom_range(0, 9))
            0, 1: frames = $urandom_range(0, 3);
            2: frames = $urandom_range(0, 65535);
            default: frames = $urandom_range(1, 30);
        endcase
        return mk_req(ACT_START, $urandom_range(0, 255), $urandom, $urandom, frames,
                      $urandom_range(0, 7), cur_frame);
    endfunction

    // Lets the sender pause until the engine has delivered every result.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tween_req_t directed [$];
        tween_req_t it;
        int pick;
        err_count    = 0;
        tween_count  = 0;
        hold_req     = 1'b0;
        burst_left   = 0;
        idle_cycles  = 0;
        cur_frame    = 32'd1000;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        action       = ACT_TICK;
        target_id    = 8'd0;
        start_value  = 32'sd0;
        end_value    = 32'sd0;
        duration     = 16'd0;
        easing       = 3'd0;
        frame_number = 32'd0;
        typed_valid  = 1'b0;
        typed_kind   = KIND_ACK;
        typed_value  = 32'd0;

        // Directed part: empty table, unused code, every curve, extreme values,
        // zero duration, frame counter wrapping, stop-all.
        directed.push_back(mk_typed(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd5),
                                    KIND_ACK, 32'd0));
        directed.push_back(mk_typed(mk_req(ACT_STOP, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                                           16'hffff, 3'd7, 32'hffff_ffff), KIND_ACK, 32'd0));
        directed.push_back(mk_typed(mk_req(ACT_SPARE, 8'd9, 1, 2, 3, 4, 32'd5),
                                    KIND_ACK, 32'd0));
        directed.push_back(mk_typed(mk_req(ACT_START, 8'hff, 32'h7fff_ffff, 32'h8000_0000,
                                           16'd100, 3'd0, 32'd0), KIND_STARTED, 32'h7fff_ffff));
        directed.push_back(mk_typed(mk_req(ACT_START, 8'h00, 32'h8000_0000, 32'h7fff_ffff,
                                           16'hffff, 3'd1, 32'hffff_fff0),
                                    KIND_STARTED, 32'h8000_0000));
        directed.push_back(mk_req(ACT_START, 8'h11, 32'h0001_0000, 32'h0064_0000, 16'd7,
                                  3'd2, 32'd10));
        directed.push_back(mk_req(ACT_START, 8'h22, 32'hfff0_0000, 32'h0010_0000, 16'd64,
                                  3'd3, 32'd10));
        directed.push_back(mk_req(ACT_START, 8'h33, 32'd0, 32'h0100_0000, 16'd60, 3'd4,
                                  32'd0));
        directed.push_back(mk_req(ACT_START, 8'h44, 32'd0, 32'h7fff_0000, 16'd90, 3'd5,
                                  32'd2));
        directed.push_back(mk_req(ACT_START, 8'h55, 32'h1234_5678, 32'h8765_4321, 16'd33,
                                  3'd6, 32'd20));
        directed.push_back(mk_req(ACT_START, 8'h66, 32'h8000_0000, 32'h0, 16'd45, 3'd7,
                                  32'd20));
        directed.push_back(mk_req(ACT_START, 8'h77, 32'h5555_aaaa, 32'haaaa_5555, 16'd0,
                                  3'd5, 32'd30));
        directed.push_back(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd30));
        directed.push_back(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd45));
        directed.push_back(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'hffff_fffe));
        directed.push_back(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd75));
        directed.push_back(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd200));
        directed.push_back(mk_typed(mk_req(ACT_STOP, 8'd0, 0, 0, 0, 0, 32'd0),
                                    KIND_ACK, 32'd0));
        directed.push_back(mk_typed(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, 32'd300),
                                    KIND_ACK, 32'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Once, fill the table to the brim and ask for one slot more.
            if (n == 60)
            begin
                send_item(mk_req(ACT_STOP, $urandom_range(0, 255), $urandom, $urandom,
                                 $urandom_range(0, 65535), $urandom_range(0, 7), $urandom));
                for (int s = 0; s <= TABLE_SLOTS; s++)
                    send_item(random_start());
                cur_frame += 2;
                send_item(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, cur_frame));
                send_item(mk_req(ACT_TICK, 8'd0, 0, 0, 0, 0, cur_frame + 5));
            end
            // Once, the receiver backs off while items keep coming.
            if (n == 100)
                hold_req = 1'b1;
            if (n == 150)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                it = mk_req(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
            else if (pick < 7)
                it = mk_req(ACT_STOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                            cur_frame);
            else if (pick < 10)
            begin
                // Frame counter jumps anywhere, wrap included.
                cur_frame = $urandom;
                it = mk_req(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                            cur_frame);
            end
            else if (pick < 45 || tween_count < 3)
                it = random_start();
            else
            begin
                cur_frame += $urandom_range(0, 8);
                it = mk_req(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                            cur_frame);
            end
            send_item(it);
        end

        drain_results();
        repeat (900) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("eased_tween_table_engine_top test passed");
        else
            $display("eased_tween_table_engine_top test failed");
        $finish;
    end
endmodule
